// ===== rtl/dgls_pkg.sv =====
// Shared types, codes and constants of the dynamic gradient loss scaler.
package dgls_pkg;

   // Operations of the shared floating-point unit.
   localparam logic [1:0] FOP_MUL  = 2'd0;
   localparam logic [1:0] FOP_DIV  = 2'd1;
   localparam logic [1:0] FOP_IDIV = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_ELEM     = 3'd0;
   localparam logic [2:0] ST_LAYER_OK = 3'd1;
   localparam logic [2:0] ST_LAYER_OV = 3'd2;
   localparam logic [2:0] ST_BAD      = 3'd3;
   localparam logic [2:0] ST_STEP     = 3'd4;
   localparam logic [2:0] ST_WINDOW   = 3'd5;

   // Gradient formats for the range check.
   localparam logic [1:0] FMT_FP32 = 2'd0;
   localparam logic [1:0] FMT_FP16 = 2'd1;
   localparam logic [1:0] FMT_FP8  = 2'd2;
   localparam logic [1:0] FMT_INT8 = 2'd3;

   // Control register indexes.
   localparam logic [2:0] REG_INIT_SCALE = 3'd0;
   localparam logic [2:0] REG_FORMAT     = 3'd1;
   localparam logic [2:0] REG_DYNAMIC    = 3'd2;
   localparam logic [2:0] REG_WINDOW     = 3'd3;
   localparam logic [2:0] REG_LIMIT      = 3'd4;
   localparam logic [2:0] REG_FACTOR     = 3'd5;
   localparam logic [2:0] REG_LAYERS     = 3'd6;

   // Reset values of the control registers.
   localparam logic [31:0] RST_INIT_SCALE = 32'h4700_0000;
   localparam logic [1:0]  RST_FORMAT     = FMT_FP16;
   localparam logic        RST_DYNAMIC    = 1'b1;
   localparam logic [15:0] RST_WINDOW     = 16'd2000;
   localparam logic [31:0] RST_LIMIT      = 32'h3D4C_CCCD;
   localparam logic [31:0] RST_FACTOR     = 32'h4000_0000;
   localparam logic [8:0]  RST_LAYERS     = 9'd256;

   // Upper bound on layer indices.
   localparam int unsigned MAX_LAYERS = 256;

   // Range limits as fp32 magnitudes.
   localparam logic [30:0] MAG_FP16     = 31'h477F_E000;
   localparam logic [30:0] MAG_FP8      = 31'h43E0_0000;
   localparam logic [30:0] MAG_INT8_POS = 31'h42FE_0000;
   localparam logic [30:0] MAG_INT8_NEG = 31'h4300_0000;

   localparam logic [31:0] NAN_DEFAULT  = 32'hFFC0_0000;
   localparam logic [31:0] NAN_POSITIVE = 32'h7FC0_0000;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] res;
   } fpu_rsp_type;

endpackage

// ===== rtl/dgls_fpu.sv =====
// Iterative fp32 multiply, divide and 16-bit unsigned integer divide unit with round-to-nearest-even.
module dgls_fpu
   import dgls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  fpu_req_type req,
   output fpu_rsp_type rsp
);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_NORM = 3'd1;
   localparam logic [2:0] F_DIV  = 3'd2;
   localparam logic [2:0] F_ADJ  = 3'd3;
   localparam logic [2:0] F_DEN  = 3'd4;
   localparam logic [2:0] F_RND  = 3'd5;
   localparam logic [2:0] F_DONE = 3'd6;

   logic [2:0]         st_ff, st_in;
   logic [1:0]         op_ff, op_in;
   logic               sgn_ff, sgn_in;
   logic [23:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic signed [10:0] ea_ff, ea_in, eb_ff, eb_in, e_ff, e_in;
   logic [47:0]        m_ff, m_in;
   logic [24:0]        rem_ff, rem_in;
   logic [25:0]        q_ff, q_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [31:0]        res_ff, res_in;

   // Operand classification.
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
   logic        special;
   logic [31:0] spec_res;
   // Division step.
   logic        ge;
   logic [24:0] rem_sub;
   logic [25:0] q_next;
   // Rounding.
   logic        g_bit, s_bit, inc;
   logic [24:0] sum;
   logic signed [10:0] e2;

   assign sgn    = req.a[31] ^ req.b[31];
   assign a_nan  = (req.a[30:23] == 8'hFF) && (req.a[22:0] != 23'd0);
   assign b_nan  = (req.b[30:23] == 8'hFF) && (req.b[22:0] != 23'd0);
   assign a_inf  = (req.a[30:23] == 8'hFF) && (req.a[22:0] == 23'd0);
   assign b_inf  = (req.b[30:23] == 8'hFF) && (req.b[22:0] == 23'd0);
   assign a_zero = (req.a[30:0] == 31'd0);
   assign b_zero = (req.b[30:0] == 31'd0);

   // Results that need no arithmetic: NaN, infinity and zero operands.
   always_comb begin
      special  = 1'b1;
      spec_res = 32'd0;
      unique case (req.op)
         FOP_IDIV: begin
            if (req.a[15:0] == 16'd0) begin
               spec_res = 32'd0;
            end else if (req.b[15:0] == 16'd0) begin
               spec_res = 32'h7F80_0000;
            end else begin
               special = 1'b0;
            end
         end
         FOP_DIV: begin
            if (a_nan) begin
               spec_res = req.a | 32'h0040_0000;
            end else if (b_nan) begin
               spec_res = req.b | 32'h0040_0000;
            end else if ((a_inf && b_inf) || (a_zero && b_zero)) begin
               spec_res = NAN_DEFAULT;
            end else if (a_inf || b_zero) begin
               spec_res = {sgn, 31'h7F80_0000};
            end else if (a_zero || b_inf) begin
               spec_res = {sgn, 31'd0};
            end else begin
               special = 1'b0;
            end
         end
         default: begin
            if (a_nan) begin
               spec_res = req.a | 32'h0040_0000;
            end else if (b_nan) begin
               spec_res = req.b | 32'h0040_0000;
            end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
               spec_res = NAN_DEFAULT;
            end else if (a_inf || b_inf) begin
               spec_res = {sgn, 31'h7F80_0000};
            end else if (a_zero || b_zero) begin
               spec_res = {sgn, 31'd0};
            end else begin
               special = 1'b0;
            end
         end
      endcase
   end

   // One restoring division step.
   assign ge      = (rem_ff >= {1'b0, mb_ff});
   assign rem_sub = ge ? (rem_ff - {1'b0, mb_ff}) : rem_ff;
   assign q_next  = {q_ff[24:0], ge};

   // Round to nearest even on the aligned mantissa.
   assign g_bit = m_ff[22];
   assign s_bit = |m_ff[21:0];
   assign inc   = g_bit & (s_bit | m_ff[23]);
   assign sum   = {1'b0, m_ff[46:23]} + {24'd0, inc};
   assign e2    = e_ff + {10'd0, sum[24]};

   // Sequencer.
   always_comb begin
      st_in  = st_ff;
      op_in  = op_ff;
      sgn_in = sgn_ff;
      ma_in  = ma_ff;
      mb_in  = mb_ff;
      ea_in  = ea_ff;
      eb_in  = eb_ff;
      e_in   = e_ff;
      m_in   = m_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      res_in = res_ff;
      unique case (st_ff)
         F_IDLE, F_DONE: begin
            // A new operation may start in the cycle its predecessor reports done.
            st_in = F_IDLE;
            if (req.start) begin
               op_in  = req.op;
               sgn_in = (req.op == FOP_IDIV) ? 1'b0 : sgn;
               if (special) begin
                  res_in = spec_res;
                  st_in  = F_DONE;
               end else begin
                  st_in = F_NORM;
                  if (req.op == FOP_IDIV) begin
                     ma_in = {8'd0, req.a[15:0]};
                     mb_in = {8'd0, req.b[15:0]};
                     ea_in = 11'sd150;
                     eb_in = 11'sd150;
                  end else begin
                     ma_in = {req.a[30:23] != 8'd0, req.a[22:0]};
                     mb_in = {req.b[30:23] != 8'd0, req.b[22:0]};
                     ea_in = (req.a[30:23] == 8'd0) ? 11'sd1 : {3'b000, req.a[30:23]};
                     eb_in = (req.b[30:23] == 8'd0) ? 11'sd1 : {3'b000, req.b[30:23]};
                  end
               end
            end
         end
         F_NORM: begin
            // Bring each mantissa to a leading one, one bit per cycle.
            if (!ma_ff[23]) begin
               ma_in = {ma_ff[22:0], 1'b0};
               ea_in = ea_ff - 11'sd1;
            end else if (!mb_ff[23]) begin
               mb_in = {mb_ff[22:0], 1'b0};
               eb_in = eb_ff - 11'sd1;
            end else if (op_ff == FOP_MUL) begin
               m_in  = ma_ff * mb_ff;
               e_in  = ea_ff + eb_ff - 11'sd127;
               st_in = F_ADJ;
            end else begin
               rem_in = {1'b0, ma_ff};
               q_in   = 26'd0;
               cnt_in = 5'd0;
               e_in   = ea_ff - eb_ff + 11'sd127;
               st_in  = F_DIV;
            end
         end
         F_DIV: begin
            q_in   = q_next;
            rem_in = {rem_sub[23:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd25) begin
               m_in  = {1'b0, q_next, 20'd0, rem_sub != 25'd0};
               st_in = F_ADJ;
            end
         end
         F_ADJ: begin
            // Put the leading one at bit 46.
            if (m_ff[47]) begin
               m_in = {1'b0, m_ff[47:2], m_ff[1] | m_ff[0]};
               e_in = e_ff + 11'sd1;
            end else if (!m_ff[46]) begin
               m_in = {m_ff[46:0], 1'b0};
               e_in = e_ff - 11'sd1;
            end
            st_in = F_DEN;
         end
         F_DEN: begin
            // Shift tiny results down to the subnormal range.
            if (e_ff >= 11'sd1) begin
               st_in = F_RND;
            end else if (e_ff < -11'sd25) begin
               m_in = {47'd0, |m_ff};
               e_in = 11'sd1;
            end else begin
               m_in = {1'b0, m_ff[47:2], m_ff[1] | m_ff[0]};
               e_in = e_ff + 11'sd1;
            end
         end
         F_RND: begin
            if (e2 >= 11'sd255) begin
               res_in = {sgn_ff, 31'h7F80_0000};
            end else begin
               res_in = {sgn_ff, (sum[24] | sum[23]) ? e2[7:0] : 8'd0, sum[22:0]};
            end
            st_in = F_DONE;
         end
         default: begin
            st_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
      op_ff  <= op_in;
      sgn_ff <= sgn_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      ea_ff  <= ea_in;
      eb_ff  <= eb_in;
      e_ff   <= e_in;
      m_ff   <= m_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign rsp.done = (st_ff == F_DONE);
   assign rsp.res  = res_ff;

endmodule

// ===== rtl/dynamic_gradient_loss_scaler.sv =====
// Top level of the dynamic gradient loss scaler: sequencer, tallies and control registers.
// Element: a multiply by the scale in the shared fp32 unit; subnormal operands and tiny
// products take extra shift steps, and zero, infinite or NaN operands skip the arithmetic.
// Rejected elements and steps that leave the window open skip the unit; a window close runs
// the ratio, then a divide or multiply if the scale changes. Requests stall until each result reaches the output.
// Synchronous reset loads the power-on loss scale and clears tallies and flags.
module dynamic_gradient_loss_scaler
   import dgls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [15:0] req_layer_index,
   input  logic [31:0] req_gradient_bits,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_scaled_bits,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_current_scale,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_DEC   = 3'd1;
   localparam logic [2:0] T_MUL   = 3'd2;
   localparam logic [2:0] T_RATIO = 3'd3;
   localparam logic [2:0] T_ADJ   = 3'd4;
   localparam logic [2:0] T_OUT   = 3'd5;

   logic [2:0]  st_ff, st_in;
   logic        op_ff, op_in, last_ff, last_in;
   logic [15:0] layer_ff, layer_in;
   logic [31:0] grad_ff, grad_in;
   logic [31:0] pend_bits_ff, pend_bits_in;
   logic [2:0]  pend_status_ff, pend_status_in;
   logic [31:0] scale_ff, scale_in;
   logic [15:0] ovf_ff, ovf_in, steps_ff, steps_in;
   logic        seen_ff, seen_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_bits_ff, rsp_bits_in, rsp_scale_ff, rsp_scale_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;

   logic [1:0]  fmt_ff;
   logic        dyn_ff;
   logic [15:0] window_ff;
   logic [31:0] limit_ff, factor_ff;
   logic [8:0]  layers_ff;

   fpu_req_type fpu_req;
   fpu_rsp_type fpu_rsp;

   logic        accept, bad_layer, fail, seen_n, above, lim_nan;
   logic [15:0] steps_n;
   logic [30:0] pmag;
   logic [31:0] p;

   dgls_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .req   (fpu_req),
      .rsp   (fpu_rsp)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (st_ff != T_IDLE);
   assign csr_ready = 1'b1;

   assign bad_layer = ({1'b0, layer_ff} >= {8'd0, layers_ff}) ||
                      ({1'b0, layer_ff} >= 17'(MAX_LAYERS));
   assign steps_n   = (steps_ff == 16'hFFFF) ? steps_ff : steps_ff + 16'd1;

   // Range check of the scaled element; NaN magnitudes exceed every limit.
   assign p    = fpu_rsp.res;
   assign pmag = p[30:0];
   always_comb begin
      unique case (fmt_ff)
         FMT_FP16: fail = (pmag > MAG_FP16);
         FMT_FP8:  fail = (pmag > MAG_FP8);
         FMT_INT8: fail = p[31] ? (pmag > MAG_INT8_NEG) : (pmag > MAG_INT8_POS);
         default:  fail = 1'b0;
      endcase
   end
   assign seen_n = seen_ff | fail;

   // Overflow ratio against the limit; the ratio is never negative nor NaN.
   assign lim_nan = (limit_ff[30:23] == 8'hFF) && (limit_ff[22:0] != 23'd0);
   assign above   = !lim_nan && (limit_ff[31] ?
                    ((p[30:0] != 31'd0) || (limit_ff[30:0] != 31'd0)) :
                    (p[30:0] > limit_ff[30:0]));

   // Item sequencer.
   always_comb begin
      st_in          = st_ff;
      op_in          = op_ff;
      last_in        = last_ff;
      layer_in       = layer_ff;
      grad_in        = grad_ff;
      pend_bits_in   = pend_bits_ff;
      pend_status_in = pend_status_ff;
      scale_in       = scale_ff;
      ovf_in         = ovf_ff;
      steps_in       = steps_ff;
      seen_in        = seen_ff;
      fpu_req.start  = 1'b0;
      fpu_req.op     = FOP_MUL;
      fpu_req.a      = grad_ff;
      fpu_req.b      = scale_ff;
      unique case (st_ff)
         T_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               last_in  = req_is_last;
               layer_in = req_layer_index;
               grad_in  = req_gradient_bits;
               st_in    = T_DEC;
            end
         end
         T_DEC: begin
            if (!op_ff) begin
               if (bad_layer) begin
                  pend_bits_in   = grad_ff;
                  pend_status_in = ST_BAD;
                  st_in          = T_OUT;
               end else begin
                  fpu_req.start = 1'b1;
                  st_in         = T_MUL;
               end
            end else begin
               steps_in     = steps_n;
               pend_bits_in = 32'd0;
               if (dyn_ff && (steps_n >= window_ff)) begin
                  fpu_req.start = 1'b1;
                  fpu_req.op    = FOP_IDIV;
                  fpu_req.a     = {16'd0, ovf_ff};
                  fpu_req.b     = {16'd0, steps_n};
                  st_in         = T_RATIO;
               end else begin
                  pend_status_in = ST_STEP;
                  st_in          = T_OUT;
               end
            end
         end
         T_MUL: begin
            if (fpu_rsp.done) begin
               pend_bits_in = p;
               if (last_ff) begin
                  pend_status_in = seen_n ? ST_LAYER_OV : ST_LAYER_OK;
                  if (seen_n && (ovf_ff != 16'hFFFF)) begin
                     ovf_in = ovf_ff + 16'd1;
                  end
                  seen_in = 1'b0;
               end else begin
                  pend_status_in = ST_ELEM;
                  seen_in        = seen_n;
               end
               st_in = T_OUT;
            end
         end
         T_RATIO: begin
            if (fpu_rsp.done) begin
               pend_status_in = ST_WINDOW;
               ovf_in         = 16'd0;
               steps_in       = 16'd0;
               st_in          = T_OUT;
               if (above) begin
                  if (factor_ff[30:0] == 31'd0) begin
                     // Zero factor: NaN stays quiet NaN, zero turns to NaN, else infinity.
                     if ((scale_ff[30:23] == 8'hFF) && (scale_ff[22:0] != 23'd0)) begin
                        scale_in = scale_ff | 32'h0040_0000;
                     end else if (scale_ff[30:0] == 31'd0) begin
                        scale_in = NAN_POSITIVE;
                     end else begin
                        scale_in = {scale_ff[31] ^ factor_ff[31], 31'h7F80_0000};
                     end
                  end else begin
                     fpu_req.start = 1'b1;
                     fpu_req.op    = FOP_DIV;
                     fpu_req.a     = scale_ff;
                     fpu_req.b     = factor_ff;
                     st_in         = T_ADJ;
                  end
               end else if (ovf_ff == 16'd0) begin
                  fpu_req.start = 1'b1;
                  fpu_req.op    = FOP_MUL;
                  fpu_req.a     = scale_ff;
                  fpu_req.b     = factor_ff;
                  st_in         = T_ADJ;
               end
            end
         end
         T_ADJ: begin
            if (fpu_rsp.done) begin
               scale_in = p;
               st_in    = T_OUT;
            end
         end
         T_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               st_in = T_IDLE;
            end
         end
         default: begin
            st_in = T_IDLE;
         end
      endcase
   end

   // Output register; loads when the pending result finds it free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_bits_in   = rsp_bits_ff;
      rsp_status_in = rsp_status_ff;
      rsp_scale_in  = rsp_scale_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((st_ff == T_OUT) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in  = 1'b1;
         rsp_bits_in   = pend_bits_ff;
         rsp_status_in = pend_status_ff;
         rsp_scale_in  = scale_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_IDLE;
         scale_ff     <= RST_INIT_SCALE;
         ovf_ff       <= 16'd0;
         steps_ff     <= 16'd0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         scale_ff     <= scale_in;
         ovf_ff       <= ovf_in;
         steps_ff     <= steps_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      last_ff        <= last_in;
      layer_ff       <= layer_in;
      grad_ff        <= grad_in;
      pend_bits_ff   <= pend_bits_in;
      pend_status_ff <= pend_status_in;
      rsp_bits_ff    <= rsp_bits_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_scale_ff   <= rsp_scale_in;
   end

   // Control registers. The initial scale only matters at reset, which also
   // restores its power-on value, so its writes are taken and dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= RST_FORMAT;
         dyn_ff    <= RST_DYNAMIC;
         window_ff <= RST_WINDOW;
         limit_ff  <= RST_LIMIT;
         factor_ff <= RST_FACTOR;
         layers_ff <= RST_LAYERS;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FORMAT:  fmt_ff    <= csr_wdata[1:0];
            REG_DYNAMIC: dyn_ff    <= csr_wdata[0];
            REG_WINDOW:  window_ff <= csr_wdata[15:0];
            REG_LIMIT:   limit_ff  <= csr_wdata;
            REG_FACTOR:  factor_ff <= csr_wdata;
            REG_LAYERS:  layers_ff <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scaled_bits   = rsp_bits_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_current_scale = rsp_scale_ff;

endmodule
